### hdl/jamq_pkg.sv
// types, constants and the median selector shared by the joystick axis quantizer
package jamq_pkg;

	// fixed configuration of the quantizer
	localparam int ADC_BITS    = 10;
	localparam int WINDOW      = 5;
	localparam int CAL_SAMPLES = 1000;
	localparam int LEVEL_STEP  = 16;
	localparam int NUM_AXES    = 3;

	// derived widths
	localparam int AXIS_W     = 2;
	localparam int LEVEL_W    = 9;
	localparam int SUM_W      = $clog2(CAL_SAMPLES * ((1 << ADC_BITS) - 1) + 1);
	localparam int COUNT_W    = $clog2(CAL_SAMPLES + 1);
	localparam int FILL_W     = $clog2(WINDOW + 1);
	localparam int DIFF_W     = ADC_BITS + 1;
	localparam int SCALED_W   = DIFF_W + 2;
	localparam int LEVEL_SHIFT = $clog2(LEVEL_STEP);

	// mean by reciprocal multiply: exact for every reachable sum
	localparam int CAL_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
	localparam longint unsigned CAL_RECIP =
		((64'd1 << CAL_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
	localparam int RECIP_W = CAL_SHIFT - $clog2(CAL_SAMPLES) + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;

	// codes
	localparam logic              MODE_CAL    = 1'b0;
	localparam logic              MODE_MEAS   = 1'b1;
	localparam logic              KIND_MEDIAN = 1'b0;
	localparam logic              KIND_CAL    = 1'b1;
	localparam logic [AXIS_W-1:0] AXIS_Z      = 2'd2;

	typedef logic signed [LEVEL_W-1:0] level_t;
	typedef logic [FILL_W-1:0]         fill_t;
	typedef level_t                    win_t [WINDOW];

	// median by rank: ties broken by position so exactly one entry has the middle rank
	function automatic level_t median_of_window(input win_t v);
		fill_t  rank;
		level_t m;
		m = v[0];
		for (int i = 0; i < WINDOW; i++) begin
			rank = '0;
			for (int j = 0; j < WINDOW; j++) begin
				if (j != i) begin
					if ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i))) begin
						rank = rank + fill_t'(1);
					end
				end
			end
			if (rank == fill_t'((WINDOW - 1) / 2)) begin
				m = v[i];
			end
		end
		return m;
	endfunction

endpackage

### hdl/joystick_axis_median_quantizer.sv
// top level: per-axis calibration, level quantizing and median-of-window filter
//
// The block takes one item per clock cycle when the result side is not stalled.
// Each item passes an input register, then combinational logic (offset subtract,
// gain of three for Z, divide by 16 toward zero, rank-based median of the
// window, mean of the calibration sum by a constant reciprocal multiply) into a
// result register, which drives out_valid and the result fields.
// Calibration items (mode 0) yield a result on every 1000th sample of an axis;
// measurement items (mode 1) yield the median level on every fifth sample of an
// axis. Items on axis code 3 are dropped. No clearing pass is needed after reset.
module joystick_axis_median_quantizer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  mode,
	input  logic [jamq_pkg::AXIS_W-1:0]           axis,
	input  logic [jamq_pkg::ADC_BITS-1:0]         sample,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  kind,
	output logic [jamq_pkg::AXIS_W-1:0]           axis_out,
	output logic signed [jamq_pkg::LEVEL_W-1:0]   level,
	output logic [jamq_pkg::ADC_BITS-1:0]         new_offset
);

	// input register
	logic                            valid_s1;
	logic                            mode_s1;
	logic [jamq_pkg::AXIS_W-1:0]     axis_s1;
	logic [jamq_pkg::ADC_BITS-1:0]   sample_s1;

	// per-axis state
	logic [jamq_pkg::ADC_BITS-1:0]   offset_q [jamq_pkg::NUM_AXES];
	logic [jamq_pkg::SUM_W-1:0]      sum_q    [jamq_pkg::NUM_AXES];
	logic [jamq_pkg::COUNT_W-1:0]    count_q  [jamq_pkg::NUM_AXES];
	jamq_pkg::fill_t                 fill_q   [jamq_pkg::NUM_AXES];
	jamq_pkg::level_t                win_q    [jamq_pkg::NUM_AXES][jamq_pkg::WINDOW];

	// result register
	logic                            out_valid_q;
	logic                            kind_q;
	logic [jamq_pkg::AXIS_W-1:0]     axis_q;
	jamq_pkg::level_t                level_q;
	logic [jamq_pkg::ADC_BITS-1:0]   offset_out_q;

	// datapath
	logic                                  ax_ok;
	logic [jamq_pkg::AXIS_W-1:0]           idx;
	logic [jamq_pkg::ADC_BITS-1:0]         off;
	logic [jamq_pkg::SUM_W-1:0]            sum_next;
	logic [jamq_pkg::COUNT_W-1:0]          count_next;
	logic                                  cal_done;
	logic [jamq_pkg::PROD_W-1:0]           prod;
	logic [jamq_pkg::ADC_BITS-1:0]         mean;
	logic signed [jamq_pkg::DIFF_W-1:0]    diff;
	logic signed [jamq_pkg::SCALED_W-1:0]  diff_ext;
	logic signed [jamq_pkg::SCALED_W-1:0]  scaled;
	logic signed [jamq_pkg::SCALED_W-1:0]  biased;
	logic signed [jamq_pkg::SCALED_W-1:0]  quot;
	jamq_pkg::level_t                      lvl;
	jamq_pkg::fill_t                       f0;
	logic                                  win_done;
	jamq_pkg::win_t                        row;
	jamq_pkg::level_t                      med;
	logic                                  produces;
	logic                                  advance;

	// axis select, axis code three is dropped
	assign ax_ok = (axis_s1 < jamq_pkg::AXIS_W'(jamq_pkg::NUM_AXES));
	assign idx   = ax_ok ? axis_s1 : '0;
	assign off   = offset_q[idx];

	// calibration accumulate and mean
	assign sum_next   = sum_q[idx] + jamq_pkg::SUM_W'(sample_s1);
	assign count_next = count_q[idx] + jamq_pkg::COUNT_W'(1);
	assign cal_done   = (count_next >= jamq_pkg::COUNT_W'(jamq_pkg::CAL_SAMPLES));
	assign prod       = jamq_pkg::PROD_W'(sum_next) * jamq_pkg::PROD_W'(jamq_pkg::CAL_RECIP);
	assign mean       = prod[jamq_pkg::CAL_SHIFT +: jamq_pkg::ADC_BITS];

	// level: offset subtract, Z gain, divide toward zero
	always_comb begin
		diff     = signed'({1'b0, sample_s1}) - signed'({1'b0, off});
		diff_ext = jamq_pkg::SCALED_W'(diff);
		if (axis_s1 == jamq_pkg::AXIS_Z) begin
			scaled = (diff_ext <<< 1) + diff_ext;
		end else begin
			scaled = diff_ext;
		end
		if (scaled < 0) begin
			biased = scaled + jamq_pkg::SCALED_W'(jamq_pkg::LEVEL_STEP - 1);
		end else begin
			biased = scaled;
		end
		quot = biased >>> jamq_pkg::LEVEL_SHIFT;
		lvl  = quot[jamq_pkg::LEVEL_W-1:0];
	end

	// window slot and median of stored levels plus the new one
	assign f0       = (fill_q[idx] >= jamq_pkg::FILL_W'(jamq_pkg::WINDOW)) ? '0 : fill_q[idx];
	assign win_done = (f0 == jamq_pkg::FILL_W'(jamq_pkg::WINDOW - 1));

	always_comb begin
		for (int k = 0; k < jamq_pkg::WINDOW; k++) begin
			row[k] = (f0 == jamq_pkg::FILL_W'(k)) ? lvl : win_q[idx][k];
		end
	end

	assign med = jamq_pkg::median_of_window(row);

	// flow control
	assign produces = valid_s1 && ax_ok && ((mode_s1 == jamq_pkg::MODE_CAL) ? cal_done : win_done);
	assign advance  = valid_s1 && (!produces || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1   <= mode;
			axis_s1   <= axis;
			sample_s1 <= sample;
		end
	end

	// per-axis calibration and fill state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < jamq_pkg::NUM_AXES; a++) begin
				offset_q[a] <= '0;
				sum_q[a]    <= '0;
				count_q[a]  <= '0;
				fill_q[a]   <= '0;
			end
		end else if (advance && ax_ok) begin
			if (mode_s1 == jamq_pkg::MODE_CAL) begin
				if (cal_done) begin
					offset_q[idx] <= mean;
					sum_q[idx]    <= '0;
					count_q[idx]  <= '0;
				end else begin
					sum_q[idx]   <= sum_next;
					count_q[idx] <= count_next;
				end
			end else begin
				fill_q[idx] <= win_done ? '0 : (f0 + jamq_pkg::fill_t'(1));
			end
		end
	end

	// window store, last slot is never needed after the median
	always_ff @(posedge clk) begin
		if (advance && ax_ok && (mode_s1 == jamq_pkg::MODE_MEAS) && !win_done) begin
			win_q[idx][f0] <= lvl;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produces) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance && produces) begin
			axis_q <= axis_s1;
			if (mode_s1 == jamq_pkg::MODE_CAL) begin
				kind_q       <= jamq_pkg::KIND_CAL;
				level_q      <= '0;
				offset_out_q <= mean;
			end else begin
				kind_q       <= jamq_pkg::KIND_MEDIAN;
				level_q      <= med;
				offset_out_q <= off;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign axis_out   = axis_q;
	assign level      = level_q;
	assign new_offset = offset_out_q;

endmodule
